### rtl/assert_macros.svh
// Assertion macros for the RTL files; only ned_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/ned_pkg.sv
// ---------------------------------------------------------------------------
// ned_pkg
// Shared types, constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package ned_pkg;
	localparam int DEF_MAX_WIDTH       = 256;
	localparam int DEF_MAX_HEIGHT      = 256;
	localparam int DEF_ANGLE_FRAC_BITS = 13;
	localparam int DIM_LIMIT           = 256;
	localparam int CORDIC_STEPS        = 24;
	localparam int CW                  = 36;
	localparam int ZW                  = 34;
	localparam logic [ZW-1:0] PI_Q30   = 34'd3373259426;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // latch query start, open ring 1
		logic seg_init;  // set up current segment start
		logic seg_adv;   // switch from the row pass to the column pass
		logic visit;     // issue read of current scan position
		logic consider;  // evaluate read data
		logic seg_next;  // step to the pair's other side, then to the next position
		logic ring_next; // advance to next ring
		logic cor_init;
		logic cor_step;
		logic finish;
	} ned_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic seg_done;
		logic last_seg;
		logic ring_last;
		logic have;
		logic cor_done;
	} ned_sts_t;

	function automatic logic [ZW-1:0] atan_q30(input logic [4:0] i);
		logic [ZW-1:0] v;
		begin
			case (i)
				5'd0: v = 34'd843314856;   5'd1: v = 34'd497837829;
				5'd2: v = 34'd263043836;   5'd3: v = 34'd133525158;
				5'd4: v = 34'd67021686;    5'd5: v = 34'd33543515;
				5'd6: v = 34'd16775850;    5'd7: v = 34'd8388437;
				5'd8: v = 34'd4194282;     5'd9: v = 34'd2097149;
				5'd10: v = 34'd1048575;    5'd11: v = 34'd524287;
				5'd12: v = 34'd262143;     5'd13: v = 34'd131071;
				5'd14: v = 34'd65535;      5'd15: v = 34'd32767;
				5'd16: v = 34'd16383;      5'd17: v = 34'd8191;
				5'd18: v = 34'd4095;       5'd19: v = 34'd2047;
				5'd20: v = 34'd1023;       5'd21: v = 34'd511;
				5'd22: v = 34'd255;        5'd23: v = 34'd127;
				default: v = '0;
			endcase
			return v;
		end
	endfunction
endpackage

### rtl/ned_if.sv
// ---------------------------------------------------------------------------
// ned_if
// Valid/ready channel interfaces for input, result and register words.
// ---------------------------------------------------------------------------
interface ned_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] row;
	logic [7:0] col;
	logic [7:0] pixel_value;
	modport source (output valid, func, row, col, pixel_value, input ready);
	modport sink (input valid, func, row, col, pixel_value, output ready);
endinterface

interface ned_out_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [8:0]  row_offset;
	logic signed [8:0]  col_offset;
	logic signed [15:0] angle;
	modport source (output valid, found, row_offset, col_offset, angle, input ready);
	modport sink (input valid, found, row_offset, col_offset, angle, output ready);
endinterface

interface ned_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [8:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/ned_ram.sv
// ---------------------------------------------------------------------------
// ned_ram
// Generic single-port RAM, one write and one read per cycle on a shared address, registered read.
// ---------------------------------------------------------------------------
module ned_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata <= mem[addr];
	end
endmodule

### rtl/ned_datapath.sv
// ---------------------------------------------------------------------------
// ned_datapath
// Ring walker, map RAM, best-candidate tracker and iterative CORDIC atan2.
// ---------------------------------------------------------------------------
module ned_datapath
	import ned_pkg::*;
#(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ned_cmd_t           cmd,
	output ned_sts_t           sts,
	// write port
	input  logic               wr_en,
	input  logic [7:0]         in_row,
	input  logic [7:0]         in_col,
	input  logic [7:0]         in_pix,
	input  logic [8:0]         width_cfg,
	input  logic [8:0]         height_cfg,
	output logic               res_found,
	output logic signed [8:0]  res_row,
	output logic signed [8:0]  res_col,
	output logic signed [15:0] res_angle
);
	localparam int CAW = $clog2(MAX_WIDTH);
	localparam int RAW = $clog2(MAX_HEIGHT);
	localparam int AW  = CAW + RAW;
	localparam int LW  = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
	localparam int LH  = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
	localparam int SH  = 30 - ANGLE_FRAC_BITS;

	localparam logic SEG_ROWS = 1'b0;
	localparam logic SEG_COLS = 1'b1;

	// effective dimensions
	logic [8:0] w_eff, h_eff;
	always_comb begin
		w_eff = width_cfg;
		if (w_eff == 9'd0) w_eff = 9'd1;
		if (w_eff > 9'(LW)) w_eff = 9'(LW);
		h_eff = height_cfg;
		if (h_eff == 9'd0) h_eff = 9'd1;
		if (h_eff > 9'(LH)) h_eff = 9'(LH);
	end

	// query registers; coordinates kept signed 11 bits
	logic signed [10:0] si_q, sj_q, off_q, pos_q, endp_q, r_q, c_q;
	logic signed [10:0] r_s1, c_s1;
	logic               valid_s1;
	logic               seg_q;   // top/bottom rows pass, then left/right columns pass
	logic               side_q;  // which of the pair
	logic               have_q;
	logic [17:0]        best_q;
	logic signed [8:0]  br_q, bc_q;
	logic [8:0]         maxr_q;

	logic signed [10:0] wi, hi;
	assign wi = 11'(w_eff);
	assign hi = 11'(h_eff);

	// segment bounds
	logic signed [10:0] lo_c, hi_c, lo_r, hi_r;
	always_comb begin
		lo_c = (sj_q - off_q < 11'sd0) ? 11'sd0 : sj_q - off_q;
		hi_c = (sj_q + off_q + 11'sd1 < wi) ? sj_q + off_q + 11'sd1 : wi;
		lo_r = (si_q - off_q < 11'sd0) ? 11'sd0 : si_q - off_q;
		hi_r = (si_q + off_q + 11'sd1 < hi) ? si_q + off_q + 11'sd1 : hi;
	end

	// current scan point
	always_comb begin
		if (seg_q == SEG_ROWS) begin
			r_q = side_q ? si_q + off_q : si_q - off_q;
			c_q = pos_q;
		end else begin
			r_q = pos_q;
			c_q = side_q ? sj_q + off_q : sj_q - off_q;
		end
	end

	logic in_map;
	assign in_map = (r_q >= 11'sd0) && (r_q < hi) && (c_q >= 11'sd0) && (c_q < wi);

	// map RAM
	logic          ram_we, ram_re, ram_q;
	logic [AW-1:0] ram_addr;
	assign ram_we = wr_en && (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH);
	assign ram_re = cmd.visit && in_map;
	always_comb begin
		if (wr_en)
			ram_addr = {RAW'(in_row), CAW'(in_col)};
		else
			ram_addr = {RAW'(r_q), CAW'(c_q)};
	end
	ned_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr),
		.wdata(in_pix != 8'd0), .rdata(ram_q)
	);

	// candidate distance
	logic signed [8:0] dr, dc;
	logic [17:0]       cand_d2;
	assign dr = 9'(r_s1 - si_q);
	assign dc = 9'(c_s1 - sj_q);
	assign cand_d2 = 18'(dr * dr) + 18'(dc * dc);

	// walker and tracker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			valid_s1 <= 1'b0;
			seg_q    <= SEG_ROWS;
			side_q   <= 1'b0;
		end else begin
			valid_s1 <= ram_re;
			r_s1     <= r_q;
			c_s1     <= c_q;
			if (cmd.load) begin
				si_q   <= 11'(in_row);
				sj_q   <= 11'(in_col);
				off_q  <= 11'sd1;
				have_q <= 1'b0;
				seg_q  <= SEG_ROWS;
				side_q <= 1'b0;
				maxr_q <= (w_eff > h_eff) ? w_eff : h_eff;
				br_q   <= '0;
				bc_q   <= '0;
			end
			if (cmd.seg_init) begin
				pos_q  <= (seg_q == SEG_ROWS) ? lo_c : lo_r;
				endp_q <= (seg_q == SEG_ROWS) ? hi_c : hi_r;
				side_q <= 1'b0;
			end
			if (cmd.seg_next) begin
				if (side_q) begin
					pos_q  <= pos_q + 11'sd1;
					side_q <= 1'b0;
				end else begin
					side_q <= 1'b1;
				end
			end
			if (cmd.ring_next) begin
				off_q <= off_q + 11'sd1;
				seg_q <= SEG_ROWS;
			end else if (cmd.seg_adv) begin
				seg_q <= SEG_COLS;
			end
			if (cmd.consider && valid_s1 && ram_q) begin
				if (!have_q || cand_d2 < best_q) begin
					have_q <= 1'b1;
					best_q <= cand_d2;
					br_q   <= dr;
					bc_q   <= dc;
				end
			end
		end
	end

	assign sts.seg_done  = (pos_q >= endp_q);
	assign sts.last_seg  = (seg_q == SEG_COLS);
	assign sts.ring_last = (off_q >= 11'(maxr_q));
	assign sts.have      = have_q;

	// CORDIC, one iteration per cycle
	logic signed [CW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, zs;
	logic [4:0]           it_q;
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (cmd.cor_init) begin
			it_q <= '0;
			if (br_q < 0) begin
				x_q <= -(CW'(br_q) <<< 24);
				y_q <= -(CW'(bc_q) <<< 24);
				z_q <= (bc_q >= 0) ? $signed(PI_Q30) : -$signed(PI_Q30);
			end else begin
				x_q <= CW'(br_q) <<< 24;
				y_q <= CW'(bc_q) <<< 24;
				z_q <= '0;
			end
		end else if (cmd.cor_step) begin
			it_q <= it_q + 5'd1;
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + $signed(atan_q30(it_q));
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - $signed(atan_q30(it_q));
			end
		end
	end
	assign sts.cor_done = (it_q == 5'(CORDIC_STEPS - 1));

	// saturate and round
	always_comb begin
		zs = z_q;
		if (zs > $signed(PI_Q30)) zs = $signed(PI_Q30);
		if (zs < -$signed(PI_Q30)) zs = -$signed(PI_Q30);
		zs = zs + (ZW'(1) <<< (SH - 1));
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_found <= have_q;
			res_row   <= have_q ? br_q : '0;
			res_col   <= have_q ? bc_q : '0;
			res_angle <= have_q ? 16'(zs >>> SH) : '0;
		end
	end
endmodule

### rtl/ned_ctrl.sv
// ---------------------------------------------------------------------------
// ned_ctrl
// Sequencer: ring and segment walk, CORDIC iterations, result handoff.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ned_ctrl
	import ned_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_func,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output logic     wr_en,
	output ned_cmd_t cmd,
	input  ned_sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_SEG, S_SEG_CHK, S_VISIT, S_CONS, S_NEXT_SEG, S_RING,
		S_COR_INIT, S_COR, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// handshake: input taken whenever idle; a finished query waits for the result slot
	assign in_ready  = (state_q == S_IDLE);
	assign wr_en     = in_valid && in_ready && (in_func == FUNC_WRITE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.load = in_valid && in_ready && (in_func == FUNC_QUERY);
			S_SEG:      cmd.seg_init = 1'b1;
			S_VISIT:    cmd.visit = 1'b1;
			S_CONS:     begin cmd.consider = 1'b1; cmd.seg_next = 1'b1; end
			S_NEXT_SEG: cmd.seg_adv = !sts.last_seg;
			S_RING:     cmd.ring_next = !sts.have && !sts.ring_last;
			S_COR_INIT: cmd.cor_init = 1'b1;
			S_COR:      cmd.cor_step = 1'b1;
			S_FIN:      cmd.finish = !out_valid_q || out_ready;
			default:    ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:     if (cmd.load) state_q <= S_SEG;
				S_SEG:      state_q <= S_SEG_CHK;
				S_SEG_CHK:  state_q <= sts.seg_done ? S_NEXT_SEG : S_VISIT;
				S_VISIT:    state_q <= S_CONS;
				S_CONS:     state_q <= S_SEG_CHK;
				S_NEXT_SEG: state_q <= sts.last_seg ? S_RING : S_SEG;
				S_RING: begin
					if (sts.have)
						state_q <= S_COR_INIT;
					else if (sts.ring_last)
						state_q <= S_FIN;
					else
						state_q <= S_SEG;
				end
				S_COR_INIT: state_q <= S_COR;
				S_COR:      if (sts.cor_done) state_q <= S_FIN;
				S_FIN:      if (cmd.finish) state_q <= S_OUT;
				S_OUT:      state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_fin_out, clk, arst_n, cmd.finish, state_q == S_OUT, "finish not followed by output")
	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, !(in_ready && state_q != S_IDLE), "ready while busy")
	`ASSERT_NEXT(a_load_seg, clk, arst_n, cmd.load, state_q == S_SEG, "query did not start walk")
endmodule

### rtl/nearest_edge_direction_core.sv
// Operation: a write is stored while idle. A query checks, reads and considers each scanned ring
// position (each side of a pair counts), sets up each segment and advances each ring, then runs
// CORDIC (set-up plus 24 iterations) when an edge is found, and then presents the word.
// Throughput: one item at a time; the next item is taken once the walk is back in idle,
// and a finished query waits in its final state while the previous result word is still held.
// Reset: arst_n clears control state, size registers go to 256; map undefined until written.
// ---------------------------------------------------------------------------
// nearest_edge_direction_core
// Edge map store with nearest-edge ring search and CORDIC direction.
// ---------------------------------------------------------------------------
module nearest_edge_direction_core
	import ned_pkg::*;
#(
	parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
	input logic      clk,
	input logic      arst_n,
	ned_in_if.sink   in_ch,
	ned_out_if.source out_ch,
	ned_cfg_if.sink  cfg
);
	ned_cmd_t   cmd;
	ned_sts_t   sts;
	logic       wr_en;
	logic [8:0] width_q, height_q;

	// register word port
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				default:    ;
			endcase
		end
	end

	ned_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_func(in_ch.func), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.wr_en(wr_en), .cmd(cmd), .sts(sts)
	);

	ned_datapath #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.wr_en(wr_en), .in_row(in_ch.row), .in_col(in_ch.col), .in_pix(in_ch.pixel_value),
		.width_cfg(width_q), .height_cfg(height_q),
		.res_found(out_ch.found), .res_row(out_ch.row_offset),
		.res_col(out_ch.col_offset), .res_angle(out_ch.angle)
	);
endmodule
